/* rtl/core/cst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and character tables shared by the tokenizer core.
// ----------------------------------------------------------------------------
package cst_pkg;

    // result event codes
    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_EOI  = 2'd2;

    // token kinds
    localparam logic [2:0] KIND_IDENT   = 3'd0;
    localparam logic [2:0] KIND_KEYWORD = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_OPER    = 3'd3;
    localparam logic [2:0] KIND_STRING  = 3'd4;
    localparam logic [2:0] KIND_SPECIAL = 3'd5;

    // scanner modes; word/number/operator share codes with the byte class
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_WORD = 3'd1;
    localparam logic [2:0] MODE_NUM  = 3'd2;
    localparam logic [2:0] MODE_OPER = 3'd3;
    localparam logic [2:0] MODE_STR  = 3'd4;

    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int         KW_COUNT = 4;
    localparam logic [3:0] KW_ALL   = 4'hF;
    localparam logic [2:0] WL_MAX   = 3'd7;

    // lambda, if, else, then; zero padded to eight positions
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{8'h6C, 8'h61, 8'h6D, 8'h62, 8'h64, 8'h61, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4, 3'd4};

    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] kind;
        logic [7:0] ch;
    } cst_res_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] wl;
        logic [3:0] km;
    } cst_state_t;

    // byte class: returns the mode code a run of this byte would open
    function automatic logic [2:0] class_of(input logic [7:0] c);
        logic [2:0] cls;
        cls = MODE_IDLE;
        case (c) inside
            [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F:                 cls = MODE_WORD;
            [8'h30:8'h39], 8'h2E:                                cls = MODE_NUM;
            8'h2D, 8'h3D, 8'h2B, 8'h21, 8'h3C, 8'h3E,
            8'h2F, 8'h2A, 8'h7C, 8'h26, 8'h25:                   cls = MODE_OPER;
            default:                                             cls = MODE_IDLE;
        endcase
        return cls;
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
               (c == 8'h3B) || (c == 8'h2C);
    endfunction

    // drop keywords that the new character at position wl rules out
    function automatic logic [3:0] kw_next(input logic [3:0] km, input logic [2:0] wl,
                                           input logic [7:0] c);
        logic [3:0] r;
        r = km;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (wl >= KW_LEN[i] || KW_TEXT[i][wl] != c) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] wl_next(input logic [2:0] wl);
        return (wl < WL_MAX) ? wl + 3'd1 : wl;
    endfunction

    function automatic logic [2:0] word_kind(input logic [3:0] km, input logic [2:0] wl);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (km[i] && KW_LEN[i] == wl) begin
                hit = 1'b1;
            end
        end
        return hit ? KIND_KEYWORD : KIND_IDENT;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/character_stream_tokenizer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// character_stream_tokenizer_core
// Streaming tokenizer: one byte per item, token characters and token ends out.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result buffer,
//   before its first result is presented.
// Throughput: one item per cycle while m_ready is high and each item gives
//   one result at most; k results (k up to 3) hold the port until all taken.
// Reset: synchronous active-low aresetn empties both stages and returns the
//   scanner to idle with every keyword still possible.
module character_stream_tokenizer_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_finish,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_event_res,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_ch_res,
    output logic            m_last
);
    import cst_pkg::*;

    logic             in_vld_reg;
    logic [7:0]       in_ch_reg;
    logic             in_fin_reg;
    cst_state_t       state_reg;
    cst_state_t       state_next;
    cst_res_t [2:0]   buf_reg;
    cst_res_t [2:0]   step_res;
    logic [1:0]       step_cnt;
    logic [1:0]       cnt_reg;
    logic [1:0]       idx_reg;
    logic             emit_done;
    logic             buf_free;
    logic             proc;
    cst_res_t         cur;

    cst_step u_step (
        .ch         (in_ch_reg),
        .finish     (in_fin_reg),
        .state_i    (state_reg),
        .state_next (state_next),
        .res_cnt    (step_cnt),
        .res        (step_res)
    );

    assign m_valid   = (cnt_reg != 2'd0);
    assign emit_done = m_valid && m_ready && (idx_reg == cnt_reg - 2'd1);
    assign buf_free  = (cnt_reg == 2'd0) || emit_done;
    assign proc      = in_vld_reg && buf_free;
    assign s_ready   = !in_vld_reg || proc;

    assign cur         = buf_reg[idx_reg];
    assign m_event_res = cur.ev;
    assign m_kind      = cur.kind;
    assign m_ch_res    = cur.ch;
    assign m_last      = (idx_reg == cnt_reg - 2'd1);

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg  <= s_ch;
            in_fin_reg <= s_finish;
        end
        if (proc) begin
            buf_reg <= step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg  <= '{mode: MODE_IDLE, wl: 3'd0, km: KW_ALL};
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (proc) begin
                state_reg <= state_next;
                cnt_reg   <= step_cnt;
                idx_reg   <= 2'd0;
            end else if (emit_done) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else if (m_valid && m_ready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/cst_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cst_step
// Per-byte scanner logic: next state and up to three results for one item.
// ----------------------------------------------------------------------------
module cst_step (
    input  wire logic [7:0]               ch,
    input  wire logic                     finish,
    input  wire cst_pkg::cst_state_t      state_i,
    output cst_pkg::cst_state_t           state_next,
    output logic [1:0]                    res_cnt,
    output cst_pkg::cst_res_t [2:0]       res
);
    import cst_pkg::*;

    logic [2:0] m;
    logic [2:0] wl;
    logic [3:0] km;
    logic [1:0] n;
    logic [2:0] wk;
    logic [2:0] pk;
    logic [2:0] cls;

    always_comb begin
        m   = state_i.mode;
        wl  = state_i.wl;
        km  = state_i.km;
        n   = 2'd0;
        res = '0;
        wk  = word_kind(state_i.km, state_i.wl);
        pk  = (state_i.mode == MODE_WORD) ? wk : state_i.mode;
        cls = class_of(ch);

        if (finish) begin
            if (m == MODE_WORD || m == MODE_NUM || m == MODE_OPER) begin
                res[n] = '{ev: EV_END, kind: pk, ch: 8'h00};
                n = n + 2'd1;
            end else if (m == MODE_STR && wl != 3'd0) begin
                // unclosed string text ends as a word
                res[n] = '{ev: EV_END, kind: wk, ch: 8'h00};
                n = n + 2'd1;
            end
            res[n] = '{ev: EV_EOI, kind: KIND_IDENT, ch: 8'h00};
            n  = n + 2'd1;
            m  = MODE_IDLE;
            wl = 3'd0;
            km = KW_ALL;
        end else if (ch == CH_QUOTE) begin
            if (m == MODE_STR) begin
                res[n] = '{ev: EV_END, kind: KIND_STRING, ch: 8'h00};
                n = n + 2'd1;
                m = MODE_IDLE;
            end else begin
                if (m != MODE_IDLE) begin
                    res[n] = '{ev: EV_END, kind: pk, ch: 8'h00};
                    n = n + 2'd1;
                end
                m = MODE_STR;
            end
            wl = 3'd0;
            km = KW_ALL;
        end else if (m == MODE_STR) begin
            km = kw_next(km, wl, ch);
            wl = wl_next(wl);
            res[n] = '{ev: EV_CHAR, kind: KIND_STRING, ch: ch};
            n = n + 2'd1;
        end else begin
            if (m != MODE_IDLE && m != cls) begin
                res[n] = '{ev: EV_END, kind: pk, ch: 8'h00};
                n  = n + 2'd1;
                m  = MODE_IDLE;
                wl = 3'd0;
                km = KW_ALL;
            end
            if (cls != MODE_IDLE) begin
                if (cls == MODE_WORD) begin
                    km = kw_next(km, wl, ch);
                    wl = wl_next(wl);
                end
                m = cls;
                res[n] = '{ev: EV_CHAR, kind: (cls == MODE_WORD) ? KIND_IDENT : cls, ch: ch};
                n = n + 2'd1;
            end else if (is_special(ch)) begin
                res[n] = '{ev: EV_CHAR, kind: KIND_SPECIAL, ch: ch};
                n = n + 2'd1;
                res[n] = '{ev: EV_END, kind: KIND_SPECIAL, ch: 8'h00};
                n = n + 2'd1;
            end
        end

        state_next = '{mode: m, wl: wl, km: km};
        res_cnt    = n;
    end

endmodule
`default_nettype wire
